### src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/bbc_pkg.sv
package bbc_pkg;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] kind;
  } qent_t;

  localparam logic [1:0] KIND_ROUND  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_UNCLOSED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LROUND = 8'd40;
  localparam logic [7:0] CH_RROUND = 8'd41;
  localparam logic [7:0] CH_LSQ    = 8'd91;
  localparam logic [7:0] CH_RSQ    = 8'd93;
  localparam logic [7:0] CH_LCURLY = 8'd123;
  localparam logic [7:0] CH_RCURLY = 8'd125;

endpackage

### src/bbc_front.sv
module bbc_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    char_byte,
  output logic          q_wr,
  output bbc_pkg::qent_t q_wdata,
  input  logic          q_full
);
  import bbc_pkg::*;

  logic keep;

  assign in_ready = !q_full;

  // Bytes that are neither brackets nor the terminator are dropped here.
  always_comb begin
    keep         = 1'b1;
    q_wdata.op   = OP_END;
    q_wdata.kind = KIND_ROUND;
    case (char_byte)
      CH_NUL: begin
        q_wdata.op = OP_END;
      end
      CH_LROUND: begin
        q_wdata.op   = OP_PUSH;
        q_wdata.kind = KIND_ROUND;
      end
      CH_LSQ: begin
        q_wdata.op   = OP_PUSH;
        q_wdata.kind = KIND_SQUARE;
      end
      CH_LCURLY: begin
        q_wdata.op   = OP_PUSH;
        q_wdata.kind = KIND_CURLY;
      end
      CH_RROUND: begin
        q_wdata.op   = OP_POP;
        q_wdata.kind = KIND_ROUND;
      end
      CH_RSQ: begin
        q_wdata.op   = OP_POP;
        q_wdata.kind = KIND_SQUARE;
      end
      CH_RCURLY: begin
        q_wdata.op   = OP_POP;
        q_wdata.kind = KIND_CURLY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_wr = in_valid && in_ready && keep;

endmodule

### src/bbc_queue.sv
module bbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bbc_pkg::qent_t wdata,
  output logic           full,
  output logic           rd_valid,
  output bbc_pkg::qent_t rdata,
  input  logic           rd
);
  import bbc_pkg::*;

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/bbc_back.sv
module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bbc_pkg::qent_t q_rdata,
  output logic           q_rd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           balanced,
  output logic [1:0]     status
);
  import bbc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Top of stack and the entry beneath it live in registers; the rest in mem.
  logic [1:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    top;
  logic [1:0]    top_next;
  logic [1:0]    below;
  logic [1:0]    err;
  logic [1:0]    err_next;
  logic          do_write;
  logic [CW-1:0] wr_full;
  logic [CW-1:0] rd_full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [1:0]    res_status;
  logic          take;

  assign take = q_valid && (q_rdata.op != OP_END || !out_valid || out_ready);
  assign q_rd = take;

  assign wr_full = count - CW'(1);
  assign rd_full = count_next - CW'(2);
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  always_comb begin
    if (err != ST_OK) begin
      res_status = err;
    end else if (count != '0) begin
      res_status = ST_UNCLOSED;
    end else begin
      res_status = ST_OK;
    end
  end

  always_comb begin
    count_next = count;
    top_next   = top;
    err_next   = err;
    do_write   = 1'b0;
    if (take) begin
      case (q_rdata.op)
        OP_END: begin
          count_next = '0;
          err_next   = ST_OK;
        end
        OP_PUSH: begin
          if (err == ST_OK) begin
            if (count == CW'(STACK_DEPTH)) begin
              err_next = ST_OVERFLOW;
            end else begin
              do_write   = (count != '0);
              top_next   = q_rdata.kind;
              count_next = count + CW'(1);
            end
          end
        end
        OP_POP: begin
          if (err == ST_OK) begin
            if (count == '0 || top != q_rdata.kind) begin
              err_next = ST_MISMATCH;
            end else begin
              top_next   = below;
              count_next = count - CW'(1);
            end
          end
        end
        default: begin
          err_next = err;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= top;
    end
    // A push writes the old top exactly where the new "below" is read from.
    if (do_write) begin
      below <= top;
    end else begin
      below <= mem[rd_addr];
    end
    top <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      err   <= err_next;
      if (take && q_rdata.op == OP_END) begin
        out_valid <= 1'b1;
        balanced  <= (res_status == ST_OK);
        status    <= res_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/bracket_balance_checker_core.sv
// channel | signals                                   | direction
// input   | in_valid, in_ready, char_byte[7:0]        | into block
// result  | out_valid, out_ready, balanced, status    | out of block
//
// One byte per cycle sustained while no result is held; a zero byte is classified
// into a 2-entry queue, then one stack step with top held in flops registers the result.
// Stack below the top two entries sits in a STACK_DEPTH x 2 bit memory.
// Reset is synchronous; no clearing pass, the stack is only read below count.
// A held result stalls a terminator at the queue head, and the bytes queued behind it.
module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       balanced,
  output logic [1:0] status
);
  import bbc_pkg::*;

  logic  q_wr;
  qent_t q_wdata;
  logic  q_full;
  logic  q_valid;
  qent_t q_rdata;
  logic  q_rd;

  bbc_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_byte (char_byte),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd_valid (q_valid),
    .rdata    (q_rdata),
    .rd       (q_rd)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .balanced  (balanced),
    .status    (status)
  );

endmodule

### src/bbc_checker.sv
`include "assert_macros.svh"

module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] char_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       balanced,
  input logic [1:0] status
);
  import bbc_pkg::*;

  `CHK_ASSERT(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid && $stable(char_byte), "input item changed while stalled")
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(balanced) && $stable(status), "result changed while stalled")
  `CHK_ASSERT(a_bal_ok, clk, rst, out_valid && balanced |-> status == ST_OK, "balanced with error status")
  `CHK_ASSERT(a_unbal_err, clk, rst, out_valid && !balanced |-> status != ST_OK, "unbalanced with ok status")
  `CHK_ASSERT(a_reset_idle, clk, rst, $past(rst) |-> !out_valid && in_ready, "not idle after reset")

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .char_byte (char_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .balanced  (balanced),
  .status    (status)
);
